/* src/sdm_pkg.sv */
package sdm_pkg;

   localparam int SLOT_W     = 4;
   localparam int VALUE_W    = 16;
   localparam int CMD_W      = 2;
   localparam int COMP_W     = 36;
   localparam int MAX_IDX_W  = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MULTIPLY   = 2'd2;

   // one term x[j]*y[k] on its way through the multiply-accumulate path
   typedef struct packed {
      logic              valid;
      logic              neg;    // term enters with a minus sign
      logic              first;  // first term of a product component
      logic              close;  // last term of a product component
      logic              head;   // component 0
      logic              tail;   // final component
      logic [SLOT_W-1:0] slot;
   } sdm_beat_type;

   typedef struct packed {
      logic stall;
      logic busy;
   } sdm_status_type;

   // Sign of x[j]*y[k] inside component j^k of the Cayley-Dickson product.
   function automatic logic cd_neg(input logic [MAX_IDX_W-1:0] j_in,
                                   input logic [MAX_IDX_W-1:0] k_in,
                                   input int levels);
      logic [MAX_IDX_W-1:0] j;
      logic [MAX_IDX_W-1:0] k;
      logic [MAX_IDX_W-1:0] t;
      logic                 neg;
      logic                 jh;
      logic                 kh;
      j   = j_in;
      k   = k_in;
      neg = 1'b0;
      for (int lv = MAX_IDX_W - 1; lv >= 0; lv--) begin
         if (lv < levels) begin
            jh    = j[lv];
            kh    = k[lv];
            j[lv] = 1'b0;
            k[lv] = 1'b0;
            case ({jh, kh})
               2'b11: begin
                  // -conj(d) b
                  neg = neg ^ 1'b1 ^ (k != '0);
                  t   = j;
                  j   = k;
                  k   = t;
               end
               2'b01: begin
                  // d a
                  t = j;
                  j = k;
                  k = t;
               end
               2'b10: begin
                  // b conj(c)
                  neg = neg ^ (k != '0);
               end
               default: begin
               end
            endcase
         end
      end
      return neg;
   endfunction

endpackage

/* src/sedenion_multiply_core.sv */
// channel | dir | data                                         | side
// req_    | in  | tdata: slot[3:0] value[19:4]                 | tuser cmd[1:0]
// rsp_    | out | tdata: out_slot[3:0] component[39:4]       | tuser all_zero, tlast last
//
// A multiply walks DIMENSION*DIMENSION term products through one shared multiplier,
// one per cycle while no stall holds the term pipeline, reading both operand memories
// at once; requests are refused until the last term has left the term pipeline.
// Reset clears the operand valid bits at once; no sweep.
// rsp_tready low freezes the term pipeline only when a finished component has
// nowhere to go; loads are still taken while a result waits.
module sedenion_multiply_core
   import sdm_pkg::*;
   #(
      parameter int DIMENSION      = 16,
      parameter int COMPONENT_BITS = 16
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  req_tvalid,
      output logic                  req_tready,
      input  logic [REQ_DATA_W-1:0] req_tdata,   // slot, value
      input  logic [CMD_W-1:0]      req_tuser,   // cmd
      output logic                  rsp_tvalid,
      input  logic                  rsp_tready,
      output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_slot, component
      output logic                  rsp_tuser,   // all_zero
      output logic                  rsp_tlast
   );

   localparam int             IDX_W    = $clog2(DIMENSION);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIMENSION - 1);
   localparam logic           ST_IDLE  = 1'b0;
   localparam logic           ST_RUN   = 1'b1;

   logic                              state_ff;
   logic                              state_in;
   logic [IDX_W-1:0]                  i_ff;
   logic [IDX_W-1:0]                  i_in;
   logic [IDX_W-1:0]                  j_ff;
   logic [IDX_W-1:0]                  j_in;
   logic [IDX_W-1:0]                  k;
   sdm_beat_type                      beat1_ff;
   sdm_beat_type                      beat1_in;
   sdm_status_type                    status;
   logic [CMD_W-1:0]                  cmd;
   logic [SLOT_W-1:0]                 slot;
   logic signed [VALUE_W-1:0]         value;
   logic                              accept;
   logic                              slot_ok;
   logic                              wr_left;
   logic                              wr_right;
   logic [IDX_W-1:0]                  wr_addr;
   logic [COMPONENT_BITS-1:0]         wr_data;
   logic                              en;
   logic                              issue;
   logic signed [COMPONENT_BITS-1:0]  left_data;
   logic signed [COMPONENT_BITS-1:0]  right_data;

   assign cmd   = req_tuser;
   assign slot  = req_tdata[SLOT_W-1:0];
   assign value = req_tdata[SLOT_W +: VALUE_W];

   assign req_tready = (state_ff == ST_IDLE) && !beat1_ff.valid && !status.busy;
   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = int'(slot) < DIMENSION;
   assign wr_left    = accept && (cmd == CMD_LOAD_LEFT) && slot_ok;
   assign wr_right   = accept && (cmd == CMD_LOAD_RIGHT) && slot_ok;
   assign wr_addr    = IDX_W'(slot);
   assign wr_data    = COMPONENT_BITS'(value);

   assign en    = !status.stall;
   assign issue = (state_ff == ST_RUN) && en;
   assign k     = i_ff ^ j_ff;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      beat1_in = beat1_ff;
      if (en) begin
         beat1_in = '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_MULTIPLY)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_RUN: begin
            if (en) begin
               beat1_in.valid = 1'b1;
               beat1_in.neg   = cd_neg(MAX_IDX_W'(j_ff), MAX_IDX_W'(k), IDX_W);
               beat1_in.first = (j_ff == '0);
               beat1_in.close = (j_ff == IDX_LAST);
               beat1_in.head  = (i_ff == '0);
               beat1_in.tail  = (i_ff == IDX_LAST);
               beat1_in.slot  = SLOT_W'(i_ff);
               j_in           = j_ff + 1'b1;
               if (j_ff == IDX_LAST) begin
                  i_in = i_ff + 1'b1;
                  if (i_ff == IDX_LAST) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         beat1_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         beat1_ff <= beat1_in;
      end
   end

   sdm_store #(
      .DEPTH (DIMENSION),
      .WIDTH (COMPONENT_BITS)
   ) u_left_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_left),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (j_ff),
      .rd_data (left_data)
   );

   sdm_store #(
      .DEPTH (DIMENSION),
      .WIDTH (COMPONENT_BITS)
   ) u_right_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_right),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (k),
      .rd_data (right_data)
   );

   sdm_mac #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .beat_in    (beat1_ff),
      .left_data  (left_data),
      .right_data (right_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .status     (status)
   );

endmodule

/* src/sdm_store.sv */
module sdm_store
   #(
      parameter int DEPTH = 16,
      parameter int WIDTH = 16
   )
   (
      input  logic                     clock,
      input  logic                     reset,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* src/sdm_mac.sv */
module sdm_mac
   import sdm_pkg::*;
   #(
      parameter int COMPONENT_BITS = 16
   )
   (
      input  logic                             clock,
      input  logic                             reset,
      input  sdm_beat_type                     beat_in,
      input  logic signed [COMPONENT_BITS-1:0] left_data,
      input  logic signed [COMPONENT_BITS-1:0] right_data,
      input  logic                             rsp_tready,
      output logic                             rsp_tvalid,
      output logic [RSP_DATA_W-1:0]            rsp_tdata,
      output logic                             rsp_tuser,
      output logic                             rsp_tlast,
      output sdm_status_type                   status
   );

   sdm_beat_type                        beat2_ff;
   logic signed [COMP_W-1:0]            prod_ff;
   logic signed [COMP_W-1:0]            prod_in;
   logic signed [2*COMPONENT_BITS-1:0]  prod_full;
   logic signed [COMP_W-1:0]            acc_ff;
   logic signed [COMP_W-1:0]            base;
   logic signed [COMP_W-1:0]            sum;
   logic                                zero_ff;
   logic                                zero_in;
   logic                                push;
   logic                                en;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [SLOT_W-1:0]                   out_slot_ff;
   logic [COMP_W-1:0]                   out_comp_ff;
   logic                                out_zero_ff;
   logic                                out_last_ff;

   assign prod_full = left_data * right_data;
   assign prod_in   = COMP_W'(prod_full);

   assign push = beat2_ff.valid && beat2_ff.close;
   assign en   = !(push && out_valid_ff && !rsp_tready);

   always_comb begin
      base         = beat2_ff.first ? '0 : acc_ff;
      sum          = beat2_ff.neg ? (base - prod_ff) : (base + prod_ff);
      zero_in      = (beat2_ff.head ? 1'b1 : zero_ff) && (sum == '0);
      out_valid_in = (out_valid_ff && !rsp_tready) || (push && en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat2_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (en) begin
            beat2_ff <= beat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         if (beat2_ff.valid) begin
            acc_ff <= sum;
         end
         if (push) begin
            zero_ff     <= zero_in;
            out_slot_ff <= beat2_ff.slot;
            out_comp_ff <= sum;
            out_zero_ff <= beat2_ff.tail && zero_in;
            out_last_ff <= beat2_ff.tail;
         end
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_comp_ff, out_slot_ff};
   assign rsp_tuser    = out_zero_ff;
   assign rsp_tlast    = out_last_ff;
   assign status.stall = !en;
   assign status.busy  = beat2_ff.valid;

endmodule

/* src/sdm_checker.sv */
module sdm_checker
   import sdm_pkg::*;
   #(
      parameter int DIMENSION = 16
   )
   (
      input logic                  clock,
      input logic                  reset,
      input logic                  rsp_tvalid,
      input logic                  rsp_tready,
      input logic [RSP_DATA_W-1:0] rsp_tdata,
      input logic                  rsp_tuser,
      input logic                  rsp_tlast
   );

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DIMENSION - 1);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_zero_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("all_zero raised before the last component");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[SLOT_W-1:0] == SLOT_LAST)
      else $error("last beat carries the wrong component index");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[SLOT_W-1:0] == $past(rsp_tdata[SLOT_W-1:0]) + 1'b1))
      else $error("component index out of order");

endmodule

bind sedenion_multiply_core sdm_checker #(
   .DIMENSION (DIMENSION)
) u_sdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
